### rtl/double_ended_queue_core_macros.svh
// Assertion macros used by the deque core RTL.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

### rtl/deq_pkg.sv
package deq_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int CNT_OUT_W = 5;
   localparam int ERR_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK = 3'd3;

   localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   // Request item, last field in the low bits.
   typedef struct packed {
      logic [4:0] pad;
      logic [WORD_W-1:0] push_value;
      logic [OP_W-1:0] opcode;
   } req_type;

   // Result item, last field in the low bits.
   typedef struct packed {
      logic [5:0] pad;
      logic [ERR_W-1:0] error_code;
      logic is_full;
      logic is_empty;
      logic [CNT_OUT_W-1:0] count;
      logic [WORD_W-1:0] rear_value;
      logic [WORD_W-1:0] front_value;
      logic popped_valid;
      logic [WORD_W-1:0] popped_value;
   } rsp_type;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

   typedef enum logic [1:0] {
      ROW_HOLD,
      ROW_SHR,
      ROW_SHL,
      ROW_WRITE
   } row_op_type;

   // Command broadcast to every cell of one row.
   typedef struct packed {
      row_op_type op;
      logic [WORD_W-1:0] value;
   } row_ctl_type;

endpackage

### rtl/deq_cell.sv
module deq_cell #(
   parameter int INDEX = 0,
   parameter int CW = 5
) (
   input  logic clock,
   input  deq_pkg::row_ctl_type ctl,
   input  logic [CW-1:0] count,
   input  logic [deq_pkg::WORD_W-1:0] left_data,
   input  logic [deq_pkg::WORD_W-1:0] right_data,
   output logic [deq_pkg::WORD_W-1:0] data
);
   import deq_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   // A write lands only in the cell just past the last occupied one.
   always_comb begin
      unique case (ctl.op)
         ROW_SHR: data_in = left_data;
         ROW_SHL: data_in = right_data;
         ROW_WRITE: data_in = (count == CW'(INDEX)) ? ctl.value : data_ff;
         ROW_HOLD: data_in = data_ff;
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### rtl/deq_row.sv
module deq_row #(
   parameter int DEPTH = 16,
   parameter int CW = 5
) (
   input  logic clock,
   input  deq_pkg::row_ctl_type ctl,
   input  logic [CW-1:0] count,
   output logic [deq_pkg::WORD_W-1:0] head0,
   output logic [deq_pkg::WORD_W-1:0] head1
);
   import deq_pkg::*;

   logic [WORD_W-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_data;
      logic [WORD_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = ctl.value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      deq_cell #(
         .INDEX(i),
         .CW(CW)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .count(count),
         .left_data(left_data),
         .right_data(right_data),
         .data(cell_data[i])
      );
   end

   assign head0 = cell_data[0];
   assign head1 = cell_data[1];

endmodule

### rtl/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words.
// The request channel (req_*) carries an opcode and a push value; every
// accepted item produces exactly one result item on the rsp_* channel with
// the popped word, the front and rear words, the count, the empty and full
// flags and an error code. Refused pushes and pops leave the queue unchanged.
// Storage is two rows of DEPTH cells holding the same words in opposite
// order: one row keeps the front word in its first cell, the other the rear
// word. Pushes and pops shift a row by one cell or write the cell at the
// current count, so the block accepts one item per clock while the result
// channel is not stalled. The result is registered: it appears on rsp_tvalid
// in the cycle after the item is accepted.
// When the receiver stalls, the result register holds its item and req_tready
// drops until it is taken; a taken result frees room for a new item in the
// same cycle. Reset empties the queue and the result register; the cell
// contents are not cleared, since only occupied cells are ever read.
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // opcode [2:0], push_value [34:3], zero [39:35]
   input  logic [deq_pkg::REQ_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // popped_value [31:0], popped_valid [32], front_value [64:33],
   // rear_value [96:65], count [101:97], is_empty [102], is_full [103],
   // error_code [105:104], zero [111:106]
   output logic [deq_pkg::RSP_W-1:0] rsp_tdata
);
   import deq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   req_type req;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [CW+CNT_OUT_W-1:0] cnt_ext;
   logic req_fire;
   logic push_op;
   logic pop_op;
   logic cnt_is_empty;
   logic cnt_is_full;
   logic push_ok;
   logic pop_ok;
   row_ctl_type fwd_ctl;
   row_ctl_type rev_ctl;
   logic [WORD_W-1:0] fwd0;
   logic [WORD_W-1:0] fwd1;
   logic [WORD_W-1:0] rev0;
   logic [WORD_W-1:0] rev1;

   assign req = req_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   assign push_op = (req.opcode == OP_PUSH_FRONT) || (req.opcode == OP_PUSH_BACK);
   assign pop_op = (req.opcode == OP_POP_FRONT) || (req.opcode == OP_POP_BACK);
   assign cnt_is_empty = (cnt_ff == '0);
   assign cnt_is_full = (cnt_ff == CW'(DEPTH));
   assign push_ok = push_op && !cnt_is_full;
   assign pop_ok = pop_op && !cnt_is_empty;

   // The forward row has the front word in cell 0, the reverse row the rear word.
   always_comb begin
      fwd_ctl.op = ROW_HOLD;
      rev_ctl.op = ROW_HOLD;
      fwd_ctl.value = req.push_value;
      rev_ctl.value = req.push_value;
      cnt_in = cnt_ff;
      if (req_fire && push_ok) begin
         cnt_in = cnt_ff + 1'b1;
         if (req.opcode == OP_PUSH_FRONT) begin
            fwd_ctl.op = ROW_SHR;
            rev_ctl.op = ROW_WRITE;
         end else begin
            fwd_ctl.op = ROW_WRITE;
            rev_ctl.op = ROW_SHR;
         end
      end else if (req_fire && pop_ok) begin
         cnt_in = cnt_ff - 1'b1;
         if (req.opcode == OP_POP_FRONT) begin
            fwd_ctl.op = ROW_SHL;
         end else begin
            rev_ctl.op = ROW_SHL;
         end
      end
   end

   deq_row #(
      .DEPTH(DEPTH),
      .CW(CW)
   ) u_fwd_row (
      .clock(clock),
      .ctl(fwd_ctl),
      .count(cnt_ff),
      .head0(fwd0),
      .head1(fwd1)
   );

   deq_row #(
      .DEPTH(DEPTH),
      .CW(CW)
   ) u_rev_row (
      .clock(clock),
      .ctl(rev_ctl),
      .count(cnt_ff),
      .head0(rev0),
      .head1(rev1)
   );

   // The result is built from the state before the item and the item itself.
   always_comb begin
      cnt_ext = (CW + CNT_OUT_W)'(cnt_in);
      rsp_in = '0;
      rsp_in.count = cnt_ext[CNT_OUT_W-1:0];
      rsp_in.front_value = cnt_is_empty ? EMPTY_WORD : fwd0;
      rsp_in.rear_value = cnt_is_empty ? EMPTY_WORD : rev0;
      if (push_op) begin
         if (cnt_is_full) begin
            rsp_in.error_code = ERR_FULL;
         end else if (req.opcode == OP_PUSH_FRONT) begin
            rsp_in.front_value = req.push_value;
            rsp_in.rear_value = cnt_is_empty ? req.push_value : rev0;
         end else begin
            rsp_in.rear_value = req.push_value;
            rsp_in.front_value = cnt_is_empty ? req.push_value : fwd0;
         end
      end else if (pop_op) begin
         if (cnt_is_empty) begin
            rsp_in.error_code = ERR_EMPTY;
         end else begin
            rsp_in.popped_valid = 1'b1;
            if (cnt_ff == CW'(1)) begin
               rsp_in.front_value = EMPTY_WORD;
               rsp_in.rear_value = EMPTY_WORD;
            end else if (req.opcode == OP_POP_FRONT) begin
               rsp_in.front_value = fwd1;
            end else begin
               rsp_in.rear_value = rev1;
            end
            rsp_in.popped_value = (req.opcode == OP_POP_FRONT) ? fwd0 : rev0;
         end
      end
      rsp_in.is_empty = (cnt_in == '0);
      rsp_in.is_full = (cnt_in == CW'(DEPTH));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_W'(rsp_ff);

   `DEQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= CW'(DEPTH))
   `DEQ_ASSERT_NEXT(a_push_grows, req_fire && push_ok, cnt_ff == $past(cnt_ff) + 1'b1)
   `DEQ_ASSERT_NEXT(a_pop_empty, req_fire && pop_op && cnt_is_empty,
      rsp_tvalid && rsp_ff.error_code == ERR_EMPTY && cnt_ff == '0)
   `DEQ_ASSERT_NEXT(a_stall_hold, rsp_valid_ff && !rsp_tready, !req_tready || rsp_tvalid)

endmodule

### sim/double_ended_queue_core_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
   import deq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_CYCLES = 90;
   localparam int MAX_PRINTED = 40;

   localparam logic [OP_W-1:0] OP_QUERY = 3'd4;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   // One entry of the stimulus queue; a hold entry makes the driver wait until
   // every predicted result has been taken.
   typedef struct {
      bit hold;
      logic [OP_W-1:0] opcode;
      logic [WORD_W-1:0] value;
   } deque_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   deque_cmd_type pending_cmds[$];
   rsp_type predicted_rsp[$];

   // Predictor state.
   logic [WORD_W-1:0] ring_words[DEPTH];
   int head_slot;
   int tail_slot;
   int stored;

   int error_count = 0;
   int result_index = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_stall = 0;
   int recv_calm = 0;
   int recv_hold = 0;
   int taken_count = 0;

   double_ended_queue_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int slot_after(input int slot);
      return (slot + 1 >= DEPTH) ? 0 : slot + 1;
   endfunction

   function automatic int slot_before(input int slot);
      return (slot == 0) ? DEPTH - 1 : slot - 1;
   endfunction

   // Applies one operation to the predictor state and returns the result item.
   function automatic rsp_type apply_deque_op(input req_type item);
      rsp_type res;
      res = '0;
      case (item.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (stored >= DEPTH) begin
               res.error_code = ERR_FULL;
            end else if (item.opcode == OP_PUSH_FRONT) begin
               head_slot = slot_before(head_slot);
               ring_words[head_slot] = item.push_value;
               stored++;
            end else begin
               ring_words[tail_slot] = item.push_value;
               tail_slot = slot_after(tail_slot);
               stored++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (stored == 0) begin
               res.error_code = ERR_EMPTY;
            end else if (item.opcode == OP_POP_FRONT) begin
               res.popped_value = ring_words[head_slot];
               head_slot = slot_after(head_slot);
               stored--;
               res.popped_valid = 1'b1;
            end else begin
               tail_slot = slot_before(tail_slot);
               res.popped_value = ring_words[tail_slot];
               stored--;
               res.popped_valid = 1'b1;
            end
         end
         default: begin
            // Query and the unused opcodes only report.
         end
      endcase
      if (stored == 0) begin
         res.front_value = EMPTY_WORD;
         res.rear_value = EMPTY_WORD;
      end else begin
         res.front_value = ring_words[head_slot];
         res.rear_value = ring_words[slot_before(tail_slot)];
      end
      res.count = CNT_OUT_W'(stored);
      res.is_empty = (stored == 0);
      res.is_full = (stored == DEPTH);
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [WORD_W-1:0] edge_word(input int pick);
      case (pick % 5)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      if ($urandom_range(0, 9) == 0) return edge_word($urandom_range(0, 4));
      return $urandom;
   endfunction

   task automatic add_op(input logic [OP_W-1:0] opcode, input logic [WORD_W-1:0] value);
      deque_cmd_type cmd;
      cmd.hold = 1'b0;
      cmd.opcode = opcode;
      cmd.value = value;
      pending_cmds = {pending_cmds, cmd};
   endtask

   task automatic add_hold();
      deque_cmd_type cmd;
      cmd.hold = 1'b1;
      cmd.opcode = OP_QUERY;
      cmd.value = '0;
      pending_cmds = {pending_cmds, cmd};
   endtask

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR: result %0d: %s", result_index, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (got !== want) report_error($sformatf("%s got %h, want %h", name, got, want));
   endtask

   // Driver: offers items from the pending queue and predicts each accepted one.
   always @(posedge clock) begin
      deque_cmd_type cmd;
      req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap = 0;
         head_slot = 0;
         tail_slot = 0;
         stored = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsp = {predicted_rsp, apply_deque_op(req_type'(req_tdata))};
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0 && pending_cmds[0].hold) begin
               req_tvalid <= 1'b0;
               if (!req_tvalid && predicted_rsp.size() == 0) pending_cmds.delete(0);
            end else if (pending_cmds.size() != 0) begin
               cmd = pending_cmds[0];
               pending_cmds.delete(0);
               item = '0;
               item.opcode = cmd.opcode;
               item.push_value = cmd.value;
               req_tdata <= item;
               req_tvalid <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else if ($urandom_range(0, 39) == 0) begin
                  send_calm = 40;
                  send_gap = 0;
               end else begin
                  send_gap = idle_len();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, and two long hold-offs that back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         recv_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            taken_count++;
            if (taken_count == 250 || taken_count == 480) recv_hold = HOLD_CYCLES;
            if (recv_calm > 0) begin
               recv_calm--;
               recv_stall = 0;
            end else if ($urandom_range(0, 39) == 0) begin
               recv_calm = 40;
               recv_stall = 0;
            end else begin
               recv_stall = idle_len();
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: checks each taken result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (predicted_rsp.size() == 0) begin
            report_error("result with no prediction waiting");
         end else begin
            want = predicted_rsp[0];
            predicted_rsp.delete(0);
            compare_field("popped_value", got.popped_value, want.popped_value);
            compare_field("popped_valid", 32'(got.popped_valid), 32'(want.popped_valid));
            compare_field("front_value", got.front_value, want.front_value);
            compare_field("rear_value", got.rear_value, want.rear_value);
            compare_field("count", 32'(got.count), 32'(want.count));
            compare_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
            compare_field("is_full", 32'(got.is_full), 32'(want.is_full));
            compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
         end
         result_index++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int made;
      int seg_len;
      int pick;
      int push_pct;
      int pop_pct;
      bit held;
      mix_type mix;
      logic [OP_W-1:0] op;

      // Directed part: empty queue, fill to full, refused pushes, spare opcodes.
      add_op(OP_QUERY, 32'hFFFF_FFFF);
      add_op(OP_POP_FRONT, 32'h0000_0000);
      add_op(OP_POP_BACK, 32'h0000_0000);
      for (int i = 0; i < DEPTH; i++) begin
         add_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, edge_word(i) ^ 32'(i / 5));
      end
      add_op(OP_PUSH_FRONT, 32'h1234_5678);
      add_op(OP_PUSH_BACK, 32'h8765_4321);
      for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++) add_op(OP_W'(o), $urandom);
      add_op(OP_POP_FRONT, 32'h0000_0000);
      add_op(OP_POP_BACK, 32'hFFFF_FFFF);
      add_hold();

      // Random part in segments that lean toward filling, draining or neither,
      // so the queue keeps swinging between empty and full.
      made = 0;
      held = 1'b0;
      while (made < RANDOM_ITEMS) begin
         mix = mix_type'($urandom_range(0, 2));
         seg_len = $urandom_range(20, 60);
         case (mix)
            MIX_FILL: begin
               push_pct = 70;
               pop_pct = 20;
            end
            MIX_DRAIN: begin
               push_pct = 20;
               pop_pct = 70;
            end
            default: begin
               push_pct = 45;
               pop_pct = 45;
            end
         endcase
         for (int k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
               op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else if (pick < push_pct + pop_pct) begin
               op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
            end else if (pick < 97) begin
               op = OP_QUERY;
            end else begin
               op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            add_op(op, random_word());
            made++;
         end
         if (!held && made >= RANDOM_ITEMS / 2) begin
            add_hold();
            held = 1'b1;
         end
      end

      // Sampled away from the rising edge so the driver's updates have settled.
      @(negedge reset);
      while (pending_cmds.size() != 0 || req_tvalid || predicted_rsp.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
